// ----- design/sps_pkg.sv -----
// ----------------------------------------------------------------------------
// sps_pkg
// Shared types, codes and the sine table of the stepper phase sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sps_pkg;

  localparam int SPS_SINE_ENTRIES = 32;
  localparam int SPS_SINE_IDX_W   = $clog2(SPS_SINE_ENTRIES);
  localparam int SPS_PHASE_W      = 7;
  localparam int SPS_LEVEL_W      = 16;
  localparam int SPS_POS_W        = 32;
  localparam int SPS_CFG_IDX_W    = 2;

  typedef enum logic [1:0] {
    MODE_FULL  = 2'd0,
    MODE_HALF  = 2'd1,
    MODE_MICRO = 2'd2,
    MODE_ALT   = 2'd3
  } sps_mode_t;

  localparam logic [SPS_CFG_IDX_W-1:0] REG_STEP_MODE  = 2'd0;
  localparam logic [SPS_CFG_IDX_W-1:0] REG_FULL_LEVEL = 2'd1;
  localparam logic [SPS_CFG_IDX_W-1:0] REG_HALF_LEVEL = 2'd2;

  localparam logic ACT_STEP = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  localparam logic DIR_CW  = 1'b0;
  localparam logic DIR_CCW = 1'b1;

  localparam logic [SPS_LEVEL_W-1:0] FULL_LEVEL_RST = 16'd40000;
  localparam logic [SPS_LEVEL_W-1:0] HALF_LEVEL_RST = 16'd28284;

  typedef struct packed {
    sps_mode_t              mode;
    logic [SPS_LEVEL_W-1:0] full_level;
    logic [SPS_LEVEL_W-1:0] half_level;
  } sps_cfg_t;

  typedef struct packed {
    logic [SPS_LEVEL_W-1:0] d;
    logic [SPS_LEVEL_W-1:0] c;
    logic [SPS_LEVEL_W-1:0] b;
    logic [SPS_LEVEL_W-1:0] a;
  } sps_coils_t;

  function automatic logic [SPS_LEVEL_W-1:0] sine_rom(input logic [SPS_SINE_IDX_W-1:0] idx);
    logic [SPS_LEVEL_W-1:0] v;
    unique case (idx)
      5'd0:  v = 16'd1608;
      5'd1:  v = 16'd4821;
      5'd2:  v = 16'd8022;
      5'd3:  v = 16'd11204;
      5'd4:  v = 16'd14359;
      5'd5:  v = 16'd17479;
      5'd6:  v = 16'd20557;
      5'd7:  v = 16'd23586;
      5'd8:  v = 16'd26557;
      5'd9:  v = 16'd29465;
      5'd10: v = 16'd32302;
      5'd11: v = 16'd35061;
      5'd12: v = 16'd37736;
      5'd13: v = 16'd40319;
      5'd14: v = 16'd42806;
      5'd15: v = 16'd45189;
      5'd16: v = 16'd47464;
      5'd17: v = 16'd49624;
      5'd18: v = 16'd51664;
      5'd19: v = 16'd53580;
      5'd20: v = 16'd55367;
      5'd21: v = 16'd57021;
      5'd22: v = 16'd58537;
      5'd23: v = 16'd59913;
      5'd24: v = 16'd61144;
      5'd25: v = 16'd62227;
      5'd26: v = 16'd63161;
      5'd27: v = 16'd63943;
      5'd28: v = 16'd64570;
      5'd29: v = 16'd65042;
      5'd30: v = 16'd65357;
      default: v = 16'd65515;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- design/sps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sps_cfg_regs
// Configuration register file: step mode and the two drive levels.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_cfg_regs
  import sps_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [SPS_CFG_IDX_W-1:0] wr_index,
  input  wire logic [SPS_LEVEL_W-1:0]   wr_data,
  output sps_cfg_t                      cfg
);

  sps_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode       <= MODE_MICRO;
      cfg_r.full_level <= FULL_LEVEL_RST;
      cfg_r.half_level <= HALF_LEVEL_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_STEP_MODE:  cfg_r.mode       <= sps_mode_t'(wr_data[1:0]);
        REG_FULL_LEVEL: cfg_r.full_level <= wr_data;
        REG_HALF_LEVEL: cfg_r.half_level <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- design/sps_coil_table.sv -----
// ----------------------------------------------------------------------------
// sps_coil_table
// Coil drive lookup and next phase for full, half and sine microstep modes.
// ----------------------------------------------------------------------------
`default_nettype none

module sps_coil_table
  import sps_pkg::*;
(
  input  sps_cfg_t                   cfg,
  input  wire logic [SPS_PHASE_W-1:0] phase,
  input  wire logic                   dir,
  output sps_coils_t                  coils,
  output logic      [SPS_PHASE_W-1:0] phase_nxt
);

  logic [2:0]                p;
  logic [1:0]                q;
  logic [SPS_SINE_IDX_W-1:0] idx;
  logic [SPS_LEVEL_W-1:0]    f;
  logic [SPS_LEVEL_W-1:0]    h;
  logic [SPS_LEVEL_W-1:0]    s;
  logic [SPS_LEVEL_W-1:0]    r;
  logic [SPS_LEVEL_W-1:0]    z;

  assign p   = phase[2:0];
  assign q   = phase[6:5];
  assign idx = phase[SPS_SINE_IDX_W-1:0];
  assign f   = cfg.full_level;
  assign h   = cfg.half_level;
  assign z   = '0;
  assign s   = sine_rom(idx);
  assign r   = sine_rom(~idx);

  always_comb begin
    coils     = '0;
    phase_nxt = '0;
    unique case (cfg.mode)
      MODE_FULL: begin
        unique case (p)
          3'd0: coils = '{d: f, c: z, b: f, a: z};
          3'd2: coils = '{d: z, c: f, b: f, a: z};
          3'd4: coils = '{d: z, c: f, b: z, a: f};
          3'd6: coils = '{d: f, c: z, b: z, a: f};
          default: coils = '0;
        endcase
        if (p[0]) begin
          phase_nxt = '0;
        end else if (dir == DIR_CCW) begin
          phase_nxt = {4'd0, p + 3'd2};
        end else begin
          phase_nxt = {4'd0, p - 3'd2};
        end
      end
      MODE_HALF: begin
        unique case (p)
          3'd0: coils = '{d: z, c: z, b: f, a: z};
          3'd1: coils = '{d: z, c: h, b: h, a: z};
          3'd2: coils = '{d: z, c: f, b: z, a: z};
          3'd3: coils = '{d: z, c: h, b: z, a: h};
          3'd4: coils = '{d: z, c: z, b: z, a: f};
          3'd5: coils = '{d: h, c: z, b: z, a: h};
          3'd6: coils = '{d: f, c: z, b: z, a: z};
          default: coils = '{d: h, c: z, b: h, a: z};
        endcase
        if (dir == DIR_CCW) begin
          phase_nxt = {4'd0, p + 3'd1};
        end else begin
          phase_nxt = {4'd0, p - 3'd1};
        end
      end
      default: begin
        if (dir == DIR_CW) begin
          unique case (q)
            2'd0: coils = '{d: s, c: z, b: r, a: z};
            2'd1: coils = '{d: r, c: z, b: z, a: s};
            2'd2: coils = '{d: z, c: s, b: z, a: r};
            default: coils = '{d: z, c: r, b: s, a: z};
          endcase
        end else begin
          unique case (q)
            2'd0: coils = '{d: z, c: s, b: r, a: z};
            2'd1: coils = '{d: z, c: r, b: z, a: s};
            2'd2: coils = '{d: s, c: z, b: z, a: r};
            default: coils = '{d: r, c: z, b: s, a: z};
          endcase
        end
        phase_nxt = phase + 7'd1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/stepper_phase_sequencer.sv -----
// ----------------------------------------------------------------------------
// stepper_phase_sequencer
// Bipolar stepper coil sequencer with full, half and sine microstep modes
// and a signed position counter.
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tuser: action; tdata: direction, position_value
//   out_     out  out_tvalid/out_tready tdata: coil_a..coil_d, position
//   cfg_     in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One item a cycle while the output is not stalled: an input register and an
// output register with the table lookup and phase/position update between them.
// A load transfer updates the position and yields no output.
// rst_n clears phase, position, valid flags and sets register defaults.
// A stalled output holds a step command in the input register (a load still
// passes); the input side keeps moving while the output register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module stepper_phase_sequencer
  import sps_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [39:0]              in_tdata,   // direction, position_value, zero pad
  input  wire logic                     in_tuser,   // action
  output logic                          out_tvalid,
  input  wire logic                     out_tready,
  output logic      [95:0]              out_tdata,  // coil_a, coil_b, coil_c, coil_d, position
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [SPS_CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SPS_LEVEL_W-1:0]   cfg_data
);

  sps_cfg_t cfg;

  logic                   s1_valid_r;
  logic                   s1_load_r;
  logic                   s1_dir_r;
  logic [SPS_POS_W-1:0]   s1_pos_r;

  logic [SPS_PHASE_W-1:0] phase_r;
  logic [SPS_PHASE_W-1:0] phase_nxt;
  logic [SPS_POS_W-1:0]   pos_r;
  logic [SPS_POS_W-1:0]   pos_nxt;

  logic                   out_valid_r;
  logic [95:0]            out_data_r;

  sps_coils_t             coils;
  logic                   s1_go;
  logic                   in_xfer;

  assign cfg_ready = 1'b1;

  sps_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sps_coil_table u_table (
    .cfg       (cfg),
    .phase     (phase_r),
    .dir       (s1_dir_r),
    .coils     (coils),
    .phase_nxt (phase_nxt)
  );

  assign s1_go     = s1_valid_r && (s1_load_r || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign in_xfer   = in_tvalid && in_tready;
  assign pos_nxt   = (s1_dir_r == DIR_CCW) ? pos_r - 32'd1 : pos_r + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_load_r <= in_tuser;
      s1_dir_r  <= in_tdata[0];
      s1_pos_r  <= in_tdata[32:1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        if (s1_load_r == ACT_LOAD) begin
          pos_r <= s1_pos_r;
        end else begin
          phase_r     <= phase_nxt;
          pos_r       <= pos_nxt;
          out_valid_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_load_r == ACT_STEP) begin
      out_data_r <= {pos_nxt, coils.d, coils.c, coils.b, coils.a};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// ----- dv/tb_stepper_phase_sequencer.sv -----
// ----------------------------------------------------------------------------
// tb_stepper_phase_sequencer
// Self-checking bench for the stepper phase sequencer. Step and load commands
// go in on the input stream and the mode and drive levels are set through
// the register port. A scoreboard keeps its own copy of the phase, position
// and registers, predicts each coil drive result and checks it field by field
// on the output stream. Both streams idle and stall in random bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stepper_phase_sequencer;
  import sps_pkg::*;

  localparam int                       CYCLE_LIMIT = 200000;
  localparam int                       NUM_PHASES  = 12;
  localparam logic [SPS_CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;

  typedef struct packed {
    logic signed [SPS_POS_W-1:0] position;
    logic [SPS_LEVEL_W-1:0]      coil_d;
    logic [SPS_LEVEL_W-1:0]      coil_c;
    logic [SPS_LEVEL_W-1:0]      coil_b;
    logic [SPS_LEVEL_W-1:0]      coil_a;
  } coil_drive_t;

  class drive_scoreboard;
    sps_mode_t                   mode;
    logic [SPS_LEVEL_W-1:0]      full_lvl;
    logic [SPS_LEVEL_W-1:0]      half_lvl;
    logic [SPS_PHASE_W-1:0]      phase;
    logic signed [SPS_POS_W-1:0] pos;
    logic [SPS_LEVEL_W-1:0]      sine_tab [32];
    coil_drive_t                 drive_q [$];
    int                          errors;

    function new();
      mode     = MODE_MICRO;
      full_lvl = 16'd40000;
      half_lvl = 16'd28284;
      phase    = '0;
      pos      = '0;
      errors   = 0;
      sine_tab = '{16'd1608, 16'd4821, 16'd8022, 16'd11204, 16'd14359, 16'd17479,
                   16'd20557, 16'd23586, 16'd26557, 16'd29465, 16'd32302, 16'd35061,
                   16'd37736, 16'd40319, 16'd42806, 16'd45189, 16'd47464, 16'd49624,
                   16'd51664, 16'd53580, 16'd55367, 16'd57021, 16'd58537, 16'd59913,
                   16'd61144, 16'd62227, 16'd63161, 16'd63943, 16'd64570, 16'd65042,
                   16'd65357, 16'd65515};
    endfunction

    function void apply_reg(logic [SPS_CFG_IDX_W-1:0] idx, logic [SPS_LEVEL_W-1:0] val);
      case (idx)
        REG_STEP_MODE:  mode = sps_mode_t'(val[1:0]);
        REG_FULL_LEVEL: full_lvl = val;
        REG_HALF_LEVEL: half_lvl = val;
        default: ;
      endcase
    endfunction

    function void accept_command(logic act, logic dir, logic [SPS_POS_W-1:0] val);
      coil_drive_t            r;
      logic [2:0]             p;
      logic [1:0]             q;
      logic [4:0]             i;
      logic [SPS_LEVEL_W-1:0] f, h, s, c;
      if (act == ACT_LOAD) begin
        pos = val;
        return;
      end
      r = '0;
      p = phase[2:0];
      f = full_lvl;
      h = half_lvl;
      case (mode)
        MODE_FULL: begin
          case (p)
            3'd0: begin r.coil_b = f; r.coil_d = f; end
            3'd2: begin r.coil_b = f; r.coil_c = f; end
            3'd4: begin r.coil_a = f; r.coil_c = f; end
            3'd6: begin r.coil_a = f; r.coil_d = f; end
            default: ;
          endcase
          if (p[0])
            phase = '0;
          else
            phase = {4'd0, (dir == DIR_CCW) ? p + 3'd2 : p - 3'd2};
        end
        MODE_HALF: begin
          case (p)
            3'd0: r.coil_b = f;
            3'd1: begin r.coil_b = h; r.coil_c = h; end
            3'd2: r.coil_c = f;
            3'd3: begin r.coil_a = h; r.coil_c = h; end
            3'd4: r.coil_a = f;
            3'd5: begin r.coil_a = h; r.coil_d = h; end
            3'd6: r.coil_d = f;
            default: begin r.coil_b = h; r.coil_d = h; end
          endcase
          phase = {4'd0, (dir == DIR_CCW) ? p + 3'd1 : p - 3'd1};
        end
        default: begin
          q = phase[6:5];
          i = phase[4:0];
          s = sine_tab[i];
          c = sine_tab[5'd31 - i];
          if (dir == DIR_CW) begin
            case (q)
              2'd0: begin r.coil_b = c; r.coil_d = s; end
              2'd1: begin r.coil_a = s; r.coil_d = c; end
              2'd2: begin r.coil_a = c; r.coil_c = s; end
              default: begin r.coil_b = s; r.coil_c = c; end
            endcase
          end else begin
            case (q)
              2'd0: begin r.coil_b = c; r.coil_c = s; end
              2'd1: begin r.coil_a = s; r.coil_c = c; end
              2'd2: begin r.coil_a = c; r.coil_d = s; end
              default: begin r.coil_b = s; r.coil_d = c; end
            endcase
          end
          phase = phase + 7'd1;
        end
      endcase
      pos = (dir == DIR_CCW) ? pos - 32'sd1 : pos + 32'sd1;
      r.position = pos;
      drive_q.push_back(r);
    endfunction

    function void compare(string name, logic [SPS_POS_W-1:0] exp_v, logic [SPS_POS_W-1:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s expected %0h actual %0h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_drive(logic [95:0] tdata);
      coil_drive_t e, a;
      a = coil_drive_t'(tdata);
      if (drive_q.size() == 0) begin
        $error("drive result with none expected: %h", tdata);
        errors++;
        return;
      end
      e = drive_q.pop_front();
      compare("coil_a", {16'd0, e.coil_a}, {16'd0, a.coil_a});
      compare("coil_b", {16'd0, e.coil_b}, {16'd0, a.coil_b});
      compare("coil_c", {16'd0, e.coil_c}, {16'd0, a.coil_c});
      compare("coil_d", {16'd0, e.coil_d}, {16'd0, a.coil_d});
      compare("position", e.position, a.position);
    endfunction

    function int pending();
      return drive_q.size();
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [39:0]              in_tdata;   // direction, position_value, zero pad
  logic                     in_tuser;   // action
  logic                     out_tvalid;
  logic                     out_tready;
  logic [95:0]              out_tdata;  // coil_a, coil_b, coil_c, coil_d, position
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [SPS_CFG_IDX_W-1:0] cfg_index;
  logic [SPS_LEVEL_W-1:0]   cfg_data;

  drive_scoreboard sb;
  bit              calm;
  int              cycle_cnt;

  stepper_phase_sequencer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("[stepper_phase_sequencer] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_drive(out_tdata);
      if (in_tvalid && in_tready) sb.accept_command(in_tuser, in_tdata[0], in_tdata[32:1]);
      if (cfg_valid && cfg_ready) sb.apply_reg(cfg_index, cfg_data);
    end
  end

  // stall the result stream in random bursts
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(input logic act, input logic dir, input logic [31:0] val);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {7'd0, val, dir};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_reg(input logic [SPS_CFG_IDX_W-1:0] idx,
                             input logic [SPS_LEVEL_W-1:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SPS_LEVEL_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int          k, n, cnt;
    logic        dir;
    logic [31:0] pv;
    logic [1:0]  mode_sel;
    sb         = new();
    calm       = 1'b0;
    cycle_cnt  = 0;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = ACT_STEP;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_STEP_MODE;
    cfg_data   = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // microstep from reset, position wrap both ways
    send_item(ACT_STEP, DIR_CW, 32'd0);
    send_item(ACT_STEP, DIR_CCW, 32'hFFFF_FFFF);
    send_item(ACT_STEP, DIR_CW, 32'd0);
    send_item(ACT_LOAD, DIR_CW, 32'h7FFF_FFFF);
    send_item(ACT_STEP, DIR_CW, 32'd0);
    send_item(ACT_LOAD, DIR_CCW, 32'h8000_0000);
    send_item(ACT_STEP, DIR_CCW, 32'd0);

    // full step entered on an odd phase, then the whole table
    program_reg(REG_STEP_MODE, {14'd0, MODE_FULL});
    send_item(ACT_STEP, DIR_CW, 32'd0);
    repeat (4) send_item(ACT_STEP, DIR_CW, 32'd0);
    send_item(ACT_STEP, DIR_CCW, 32'd0);

    // half step with level extremes
    program_reg(REG_FULL_LEVEL, 16'hFFFF);
    program_reg(REG_HALF_LEVEL, 16'h0000);
    program_reg(REG_STEP_MODE, {14'd0, MODE_HALF});
    repeat (8) send_item(ACT_STEP, DIR_CW, 32'd0);
    repeat (2) send_item(ACT_STEP, DIR_CCW, 32'd0);

    // mode three and a write past the register list
    program_reg(REG_UNUSED, 16'hFFFF);
    program_reg(REG_STEP_MODE, {14'd0, MODE_ALT});
    send_item(ACT_STEP, DIR_CW, 32'd0);
    send_item(ACT_STEP, DIR_CCW, 32'd0);

    dir = DIR_CW;
    for (k = 0; k < NUM_PHASES; k++) begin
      mode_sel = (k < 4) ? k[1:0] : 2'($urandom_range(0, 3));
      program_reg(REG_STEP_MODE, {14'($urandom()), mode_sel});
      if ($urandom_range(0, 1)) program_reg(REG_FULL_LEVEL, pick_level());
      if ($urandom_range(0, 1)) program_reg(REG_HALF_LEVEL, pick_level());
      if ($urandom_range(0, 3) == 0) program_reg(REG_UNUSED, 16'($urandom()));
      if (k == NUM_PHASES - 1) calm = 1'b1;
      cnt = $urandom_range(40, 60);
      for (n = 0; n < cnt; n++) begin
        if ($urandom_range(0, 7) == 0) dir = ~dir;
        if ($urandom_range(0, 6) == 0) begin
          case ($urandom_range(0, 3))
            0: pv = 32'h7FFF_FFFF - $urandom_range(0, 2);
            1: pv = 32'h8000_0000 + $urandom_range(0, 2);
            default: pv = $urandom();
          endcase
          send_item(ACT_LOAD, 1'($urandom_range(0, 1)), pv);
        end else begin
          send_item(ACT_STEP, dir, $urandom());
        end
        if (k == 5 && n == cnt / 2) drain_results();
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("[stepper_phase_sequencer] OK");
    end else begin
      $display("[stepper_phase_sequencer] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
